### hdl/pli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg : shared types and constants of the proximity LED pattern indicator
// Pattern codes, register indexes, reset thresholds and the blink sequencer.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned IDX_W   = 2;

  localparam logic [CNT_W-1:0]   CNT_MAX = 5'd31;

  localparam logic [RANGE_W-1:0] NEAR_RST  = 16'd150;
  localparam logic [RANGE_W-1:0] CLOSE_RST = 16'd300;
  localparam logic [RANGE_W-1:0] MID_RST   = 16'd500;

  // LED patterns
  typedef enum logic [2:0] {
    PAT_OFF       = 3'd0,
    PAT_SOLID_ON  = 3'd1,
    PAT_SOLID_OFF = 3'd2,
    PAT_SLOW      = 3'd3,
    PAT_FAST      = 3'd4,
    PAT_DOUBLE    = 3'd5,
    PAT_TRIPLE    = 3'd6,
    PAT_SOS       = 3'd7
  } pat_t;

  // Raw range status codes with a meaning of their own
  localparam logic [CODE_W-1:0] STS_VALID  = 4'd0;
  localparam logic [CODE_W-1:0] STS_SIGMA  = 4'd1;
  localparam logic [CODE_W-1:0] STS_SIGNAL = 4'd2;
  localparam logic [CODE_W-1:0] STS_WRAP   = 4'd5;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_NEAR  = 2'd0,
    REG_CLOSE = 2'd1,
    REG_MID   = 2'd2
  } reg_idx_t;

  // Configuration write word as passed between modules
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   index;
    logic [RANGE_W-1:0] data;
  } cfg_wr_t;

  // One sequencer step: LED level and next counter value
  typedef struct packed {
    logic             led;
    logic [CNT_W-1:0] cnt;
  } seq_step_t;

  // Step a pattern from counter value c. Segments alternate on, off, ...;
  // once the last segment end is reached the LED is off and the count
  // restarts at one. Static patterns count up and saturate.
  function automatic seq_step_t seq_eval(input pat_t pat, input logic [CNT_W-1:0] c);
    seq_step_t r;
    logic      wrap;
    r.led = 1'b0;
    r.cnt = c + 5'd1;
    wrap  = 1'b0;
    unique case (pat)
      PAT_SLOW: begin
        if (c < 5'd10)      r.led = 1'b1;
        else if (c >= 5'd20) wrap = 1'b1;
      end
      PAT_FAST: begin
        if (c < 5'd4)       r.led = 1'b1;
        else if (c >= 5'd8) wrap = 1'b1;
      end
      PAT_DOUBLE: begin
        if (c < 5'd2 || (c >= 5'd4 && c < 5'd6)) r.led = 1'b1;
        else if (c >= 5'd12)                      wrap = 1'b1;
      end
      PAT_TRIPLE: begin
        if (c < 5'd2 || (c >= 5'd4 && c < 5'd6) || (c >= 5'd8 && c < 5'd10))
          r.led = 1'b1;
        else if (c >= 5'd16)
          wrap = 1'b1;
      end
      PAT_SOS: begin
        if (c < 5'd1 || c == 5'd2 || c == 5'd4 || (c >= 5'd8 && c < 5'd11) ||
            (c >= 5'd12 && c < 5'd15) || (c >= 5'd16 && c < 5'd19))
          r.led = 1'b1;
        else if (c >= 5'd22)
          wrap = 1'b1;
      end
      default: begin
        // off, solid on, solid off
        r.led = (pat == PAT_SOLID_ON);
        r.cnt = (c < CNT_MAX) ? c + 5'd1 : c;
      end
    endcase
    if (wrap) begin
      r.led = 1'b0;
      r.cnt = 5'd1;
    end
    return r;
  endfunction

endpackage

### hdl/pli_pattern_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pattern_sel : threshold registers and status pattern choice
// Holds the three distance limits and maps flags, status and range to a pattern.
// ----------------------------------------------------------------------------
module pli_pattern_sel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pli_pkg::cfg_wr_t              cfg_wr,
  input  logic                          data_ready,
  input  logic                          read_ok,
  input  logic [pli_pkg::CODE_W-1:0]    status_code,
  input  logic [pli_pkg::RANGE_W-1:0]   distance,
  output pli_pkg::pat_t                 pattern
);
  import pli_pkg::*;

  logic [RANGE_W-1:0] near_limit_r;
  logic [RANGE_W-1:0] close_limit_r;
  logic [RANGE_W-1:0] mid_limit_r;

  // Threshold registers; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_limit_r  <= NEAR_RST;
      close_limit_r <= CLOSE_RST;
      mid_limit_r   <= MID_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_NEAR:  near_limit_r  <= cfg_wr.data;
        REG_CLOSE: close_limit_r <= cfg_wr.data;
        REG_MID:   mid_limit_r   <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Pattern choice: flags first, then status code, then distance zone
  always_comb begin
    priority if (!data_ready) begin
      pattern = PAT_DOUBLE;
    end else if (!read_ok) begin
      pattern = PAT_TRIPLE;
    end else if (status_code == STS_VALID) begin
      priority if (distance < near_limit_r)  pattern = PAT_SOLID_ON;
      else if (distance < close_limit_r)     pattern = PAT_FAST;
      else if (distance < mid_limit_r)       pattern = PAT_SLOW;
      else                                   pattern = PAT_OFF;
    end else if (status_code == STS_SIGMA) begin
      pattern = PAT_DOUBLE;
    end else if (status_code == STS_SIGNAL) begin
      pattern = PAT_TRIPLE;
    end else if (status_code == STS_WRAP) begin
      pattern = PAT_FAST;
    end else begin
      pattern = PAT_SOS;
    end
  end

endmodule

### hdl/pli_led_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_led_seq : blink sequencer for one LED
// Tick counter and pattern lookup; restart clears the count before the step.
// ----------------------------------------------------------------------------
module pli_led_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          restart,
  input  pli_pkg::pat_t pattern,
  output logic          led
);
  import pli_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_use;
  seq_step_t        step;

  // Step from the current (or cleared) count
  always_comb begin
    count_use = restart ? '0 : count_r;
    step      = seq_eval(pattern, count_use);
    led       = step.led;
    count_nxt = step.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
    end
  end

endmodule

### hdl/proximity_led_pattern_indicator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_led_pattern_indicator : status and heartbeat LED driver
// One input word per 50 ms tick; one LED word out per tick.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in_     | in        | in_valid/in_stall  | data_ready, read_ok, status_code, distance
// out_    | out       | out_valid/out_stall| status_led, heartbeat_led
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// From acceptance a word goes into the input register, then through the pattern
// choice and counter step into the result register. One word per cycle when
// not stalled. cfg_ready is always high. Reset is synchronous; the pattern starts
// at slow blink, counters at zero. out_stall backs up via both registers to in_stall.
// ----------------------------------------------------------------------------
module proximity_led_pattern_indicator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_data_ready,
  input  logic                          in_read_ok,
  input  logic [pli_pkg::CODE_W-1:0]    in_status_code,
  input  logic [pli_pkg::RANGE_W-1:0]   in_distance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status_led,
  output logic                          out_heartbeat_led,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pli_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pli_pkg::RANGE_W-1:0]   cfg_data
);
  import pli_pkg::*;

  logic               s1_valid_r;
  logic               s1_ready_r;
  logic               s1_ok_r;
  logic [CODE_W-1:0]  s1_code_r;
  logic [RANGE_W-1:0] s1_range_r;

  logic               out_valid_r;
  logic               out_status_r;
  logic               out_heart_r;

  pat_t               pattern_r;
  pat_t               pat_sel;
  logic               pat_change;
  logic               out_free;
  logic               s1_move;
  logic               s1_free;
  logic               status_led;
  logic               heart_led;
  cfg_wr_t            cfg_wr;

  // Flow control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_ready_r <= in_data_ready;
      s1_ok_r    <= in_read_ok;
      s1_code_r  <= in_status_code;
      s1_range_r <= in_distance;
    end
  end

  pli_pattern_sel u_sel (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .data_ready  (s1_ready_r),
    .read_ok     (s1_ok_r),
    .status_code (s1_code_r),
    .distance    (s1_range_r),
    .pattern     (pat_sel)
  );

  // Current status pattern; a change restarts the status counter
  assign pat_change = (pat_sel != pattern_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PAT_SLOW;
    end else if (s1_move) begin
      pattern_r <= pat_sel;
    end
  end

  pli_led_seq u_status (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_move),
    .restart (pat_change),
    .pattern (pat_sel),
    .led     (status_led)
  );

  pli_led_seq u_heart (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_move),
    .restart (1'b0),
    .pattern (PAT_SLOW),
    .led     (heart_led)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r <= status_led;
      out_heart_r  <= heart_led;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_led    = out_status_r;
  assign out_heartbeat_led = out_heart_r;

endmodule

### sim/proximity_led_pattern_indicator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_led_pattern_indicator_tb : self-checking bench for the LED driver
// Sends tick words with random gaps and stalls the LED words at random. Every
// accepted tick steps a local model of the pattern choice and both blink
// counters, and each LED word taken is checked against the oldest prediction.
// Covers zone edges, every status code, the flag cases, threshold extremes,
// unordered thresholds, long runs that wrap or saturate the counters.
// ----------------------------------------------------------------------------
module proximity_led_pattern_indicator_tb;
  import pli_pkg::*;

  // status nibbles that fall through to SOS
  localparam logic [CODE_W-1:0] STS_UNNAMED = 4'd3;
  localparam logic [CODE_W-1:0] STS_LAST    = 4'hF;
  // register index with no register behind it
  localparam logic [IDX_W-1:0]  REG_SPARE   = 2'd3;

  typedef struct packed {
    logic               data_ready;
    logic               read_ok;
    logic [CODE_W-1:0]  status_code;
    logic [RANGE_W-1:0] distance;
  } tick_t;

  typedef struct packed {
    logic status_led;
    logic heartbeat_led;
  } led_word_t;

  typedef struct packed {
    logic             lit;
    logic [CNT_W-1:0] next_cnt;
  } blink_t;

  // segment ends, element 0 first; segments run on, off, on, ...
  typedef logic [11:0][CNT_W-1:0] seg_ends_t;
  localparam seg_ends_t SLOW_ENDS   = {50'd0, 5'd20, 5'd10};
  localparam seg_ends_t FAST_ENDS   = {50'd0, 5'd8, 5'd4};
  localparam seg_ends_t DOUBLE_ENDS = {40'd0, 5'd12, 5'd6, 5'd4, 5'd2};
  localparam seg_ends_t TRIPLE_ENDS = {30'd0, 5'd16, 5'd10, 5'd8, 5'd6, 5'd4, 5'd2};
  localparam seg_ends_t SOS_ENDS    = {5'd22, 5'd19, 5'd16, 5'd15, 5'd12, 5'd11,
                                       5'd8, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};

  logic clk = 1'b0;
  logic rst_n;

  logic                in_valid;
  logic                in_stall;
  logic                in_data_ready;
  logic                in_read_ok;
  logic [CODE_W-1:0]   in_status_code;
  logic [RANGE_W-1:0]  in_distance;
  logic                out_valid;
  logic                out_stall;
  logic                out_status_led;
  logic                out_heartbeat_led;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [RANGE_W-1:0]  cfg_data;

  // model state: thresholds, current pattern and both counters
  logic [RANGE_W-1:0] near_mm  = NEAR_RST;
  logic [RANGE_W-1:0] close_mm = CLOSE_RST;
  logic [RANGE_W-1:0] mid_mm   = MID_RST;
  pat_t               led_pat  = PAT_SLOW;
  logic [CNT_W-1:0]   led_cnt  = '0;
  logic [CNT_W-1:0]   beat_cnt = '0;

  led_word_t   pending_leds[$];
  int unsigned faults = 0;
  bit          calm   = 1'b0;   // no gaps and no stalls on either side

  proximity_led_pattern_indicator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_ready    (in_data_ready),
    .in_read_ok       (in_read_ok),
    .in_status_code   (in_status_code),
    .in_distance      (in_distance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status_led   (out_status_led),
    .out_heartbeat_led(out_heartbeat_led),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // pattern wanted for one tick
  function automatic pat_t pick_pattern(input tick_t t);
    if (!t.data_ready) return PAT_DOUBLE;
    if (!t.read_ok) return PAT_TRIPLE;
    case (t.status_code)
      STS_VALID: begin
        if (t.distance < near_mm) return PAT_SOLID_ON;
        if (t.distance < close_mm) return PAT_FAST;
        if (t.distance < mid_mm) return PAT_SLOW;
        return PAT_OFF;
      end
      STS_SIGMA:  return PAT_DOUBLE;
      STS_SIGNAL: return PAT_TRIPLE;
      STS_WRAP:   return PAT_FAST;
      default:    return PAT_SOS;
    endcase
  endfunction

  // LED level for counter value cnt and the counter after the tick
  function automatic blink_t blink_step(input pat_t pat, input logic [CNT_W-1:0] cnt);
    blink_t    r;
    seg_ends_t ends;
    int        n;
    int        i;
    r.lit      = 1'b0;
    r.next_cnt = 5'd1;
    ends       = '0;
    n          = 0;
    case (pat)
      PAT_SLOW:   begin ends = SLOW_ENDS;   n = 2;  end
      PAT_FAST:   begin ends = FAST_ENDS;   n = 2;  end
      PAT_DOUBLE: begin ends = DOUBLE_ENDS; n = 4;  end
      PAT_TRIPLE: begin ends = TRIPLE_ENDS; n = 6;  end
      PAT_SOS:    begin ends = SOS_ENDS;    n = 12; end
      default: begin
        // static patterns: count up and hold at the top
        r.lit      = (pat == PAT_SOLID_ON);
        r.next_cnt = (cnt == CNT_MAX) ? cnt : cnt + 5'd1;
        return r;
      end
    endcase
    for (i = 0; i < n; i++) begin
      if (cnt < ends[i]) begin
        r.lit      = (i % 2 == 0);
        r.next_cnt = cnt + 5'd1;
        return r;
      end
    end
    // past the last segment: off and restart at one
    return r;
  endfunction

  function automatic tick_t tick_of(input logic rdy, input logic ok,
                                    input logic [CODE_W-1:0] code,
                                    input logic [RANGE_W-1:0] distance);
    tick_t t;
    t.data_ready  = rdy;
    t.read_ok     = ok;
    t.status_code = code;
    t.distance    = distance;
    return t;
  endfunction

  // range mostly at a threshold edge, otherwise anywhere
  function automatic logic [RANGE_W-1:0] pick_range();
    logic [RANGE_W-1:0] base;
    logic [RANGE_W-1:0] wide;
    logic [RANGE_W-1:0] step;
    step = RANGE_W'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: base = near_mm;
      1: base = close_mm;
      2: base = mid_mm;
      default: begin
        wide = RANGE_W'($urandom_range(0, 65535));
        return wide;
      end
    endcase
    return base + step - 16'd1;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.data_ready = ($urandom_range(0, 9) != 0);
    t.read_ok    = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 1) == 1) t.status_code = STS_VALID;
    else t.status_code = CODE_W'($urandom_range(0, 15));
    t.distance = pick_range();
    return t;
  endfunction

  task automatic note_fault(input string what, input int unsigned want,
                            input int unsigned got);
    faults++;
    if (faults <= 10)
      $display("%0t: %s: expected %0d, actual %0d", $time, what, want, got);
  endtask

  // drive one tick word, wait until taken, then step the model
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    bit          taken;
    pat_t        want_pat;
    blink_t      s_step;
    blink_t      h_step;
    led_word_t   w;
    gap = calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_ready  <= t.data_ready;
    in_read_ok     <= t.read_ok;
    in_status_code <= t.status_code;
    in_distance    <= t.distance;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    // a new pattern restarts the status counter
    want_pat = pick_pattern(t);
    if (want_pat != led_pat) begin
      led_pat = want_pat;
      led_cnt = '0;
    end
    s_step   = blink_step(led_pat, led_cnt);
    led_cnt  = s_step.next_cnt;
    h_step   = blink_step(PAT_SLOW, beat_cnt);
    beat_cnt = h_step.next_cnt;
    w.status_led    = s_step.lit;
    w.heartbeat_led = h_step.lit;
    pending_leds.push_back(w);
  endtask

  // stop sending and wait for every predicted word
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_leds.size() != 0);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [RANGE_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_limits(input logic [RANGE_W-1:0] n_mm,
                              input logic [RANGE_W-1:0] c_mm,
                              input logic [RANGE_W-1:0] m_mm);
    drain_results();
    cfg_write(REG_NEAR, n_mm);
    cfg_write(REG_CLOSE, c_mm);
    cfg_write(REG_MID, m_mm);
    cfg_write(REG_SPARE, RANGE_W'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    near_mm  = n_mm;
    close_mm = c_mm;
    mid_mm   = m_mm;
  endtask

  // reset thresholds: zone edges, status codes and flag cases
  task automatic test_directed();
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd400));  // same as reset pattern
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd0));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd149));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd150));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd299));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd300));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd499));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd500));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd65535));
    send_tick(tick_of(1'b1, 1'b1, STS_SIGMA, 16'd0));
    send_tick(tick_of(1'b1, 1'b1, STS_SIGNAL, 16'd65535));
    send_tick(tick_of(1'b1, 1'b1, STS_WRAP, 16'd0));
    send_tick(tick_of(1'b1, 1'b1, STS_LAST, 16'd100));
    send_tick(tick_of(1'b1, 1'b1, STS_UNNAMED, 16'd100));  // still SOS, no restart
    send_tick(tick_of(1'b0, 1'b1, STS_VALID, 16'd0));      // not ready
    send_tick(tick_of(1'b0, 1'b0, STS_LAST, 16'd65535));
    send_tick(tick_of(1'b1, 1'b0, STS_VALID, 16'd0));      // read failed
  endtask

  // threshold extremes and thresholds out of order
  task automatic test_thresholds();
    write_limits(16'd0, 16'd0, 16'd0);
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd0));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd65535));
    write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd0));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd65535));
    write_limits(16'd100, 16'd50, 16'd1000);
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd60));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd100));
    send_tick(tick_of(1'b1, 1'b1, STS_VALID, 16'd1000));
  endtask

  // runs of one tick word, long enough to wrap or saturate the counters,
  // mixed with short runs and lone words; new thresholds per chunk
  task automatic test_random_ticks();
    int unsigned sent;
    int unsigned chunk;
    int unsigned run;
    logic [RANGE_W-1:0] a_mm;
    logic [RANGE_W-1:0] b_mm;
    logic [RANGE_W-1:0] c_mm;
    tick_t t;
    sent = 0;
    while (sent < 500) begin
      case ($urandom_range(0, 7))
        0: write_limits(16'd0, 16'd0, 16'd0);
        1: write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: begin
          a_mm = RANGE_W'($urandom_range(0, 65535));
          b_mm = RANGE_W'($urandom_range(0, 65535));
          c_mm = RANGE_W'($urandom_range(0, 65535));
          write_limits(a_mm, b_mm, c_mm);
        end
        default: begin
          a_mm = RANGE_W'($urandom_range(0, 20000));
          b_mm = a_mm + RANGE_W'($urandom_range(0, 20000));
          c_mm = b_mm + RANGE_W'($urandom_range(0, 20000));
          write_limits(a_mm, b_mm, c_mm);
        end
      endcase
      calm  = ($urandom_range(0, 3) == 0);
      chunk = 0;
      while (chunk < 60) begin
        t = random_tick();
        if ($urandom_range(0, 9) == 0) run = 1;
        else if ($urandom_range(0, 2) == 0) run = $urandom_range(10, 40);
        else run = $urandom_range(1, 4);
        repeat (run) begin
          // fields that the flags make irrelevant keep changing
          if (!(t.data_ready && t.read_ok)) begin
            t.status_code = CODE_W'($urandom_range(0, 15));
            t.distance    = RANGE_W'($urandom_range(0, 65535));
          end
          send_tick(t);
        end
        chunk += run;
      end
      sent += chunk;
    end
    calm = 1'b0;
  endtask

  // LED side stall: a fresh random hold of out_stall before each word, none when calm
  initial begin : stall_leds
    int unsigned hold;
    bit          taken;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold == 0) begin
        out_stall <= 1'b0;
      end else begin
        repeat (hold) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        taken = rst_n && (out_valid === 1'b1);
        @(posedge clk);
      end while (!taken);
    end
  end

  // check each LED word taken against the oldest prediction
  always @(negedge clk) begin : check_leds
    led_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_leds.size() == 0) begin
        note_fault("LED word with nothing predicted", 0,
                   32'({out_status_led, out_heartbeat_led}));
      end else begin
        want = pending_leds.pop_front();
        if (out_status_led !== want.status_led)
          note_fault("status_led", 32'(want.status_led), 32'(out_status_led));
        if (out_heartbeat_led !== want.heartbeat_led)
          note_fault("heartbeat_led", 32'(want.heartbeat_led),
                     32'(out_heartbeat_led));
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_ready  <= 1'b0;
    in_read_ok     <= 1'b0;
    in_status_code <= STS_VALID;
    in_distance    <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_NEAR;
    cfg_data       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_thresholds();
    test_random_ticks();
    drain_results();
    // a little slack for any stray word
    repeat (4) @(posedge clk);
    if (faults == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
